>>> rtl/srarq_pkg.sv
package srarq_pkg;

  // sizing
  localparam int MAX_FRAMES = 128;
  localparam int MAX_WINDOW = 32;

  localparam int IDX_W   = $clog2(MAX_FRAMES);
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
  localparam int LIM_W   = ((CNT_W > WIN_W) ? CNT_W : WIN_W) + 1;
  localparam int STAMP_W = 16;

  // field widths
  localparam int ACTION_W  = 2;
  localparam int FRAME_W   = 7;
  localparam int KIND_W    = 2;
  localparam int TOTAL_W   = 8;
  localparam int WINDOW_W  = 6;
  localparam int TIMEOUT_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [TOTAL_W-1:0]   TOTAL_RST   = 8'd16;
  localparam logic [WINDOW_W-1:0]  WINDOW_RST  = 6'd4;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 8'd2;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_START = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ACK   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_NEW  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RETX = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [FRAME_W-1:0]  ack_number;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_number;
    logic [KIND_W-1:0]  kind;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0]   total;
    logic [WINDOW_W-1:0]  window;
    logic [TIMEOUT_W-1:0] timeout;
  } cfg_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic             wdata;
  } ack_wr_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [STAMP_W-1:0] wdata;
  } stamp_wr_t;

endpackage

>>> rtl/srarq_ram.sv
module srarq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> rtl/srarq_ctrl.sv
module srarq_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  srarq_pkg::cfg_t                     cfg_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  srarq_pkg::in_item_t                 in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output srarq_pkg::out_item_t                out_item_o,
  output srarq_pkg::ack_wr_t                  ack_wr_o,
  output srarq_pkg::stamp_wr_t                stamp_wr_o,
  output logic [srarq_pkg::IDX_W-1:0]         raddr_o,
  input  logic                                ack_rd_i,
  input  logic [srarq_pkg::STAMP_W-1:0]       stamp_rd_i
);

  import srarq_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_WALK_RD  = 3'd1;
  localparam logic [2:0] S_WALK_CHK = 3'd2;
  localparam logic [2:0] S_FIN      = 3'd3;
  localparam logic [2:0] S_SEND     = 3'd4;
  localparam logic [2:0] S_TSCAN    = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [CNT_W-1:0]   base_q, base_d;
  logic [CNT_W-1:0]   next_q, next_d;
  logic [STAMP_W-1:0] tick_q, tick_d;
  logic               active_q, active_d;
  logic [CNT_W-1:0]   total_q, total_d;
  logic [WIN_W-1:0]   win_q, win_d;
  logic [CNT_W-1:0]   scan_q, scan_d;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic               rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]   hold_q, hold_d;
  logic               hold_vld_q, hold_vld_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic               accept;
  logic               can_emit;
  logic               emit;
  out_item_t          emit_item;
  logic [CNT_W-1:0]   total_sat;
  logic [WIN_W-1:0]   win_sat;
  logic [LIM_W-1:0]   lim;
  logic [LIM_W-1:0]   next_w;
  logic [LIM_W-1:0]   next_p1_w;
  logic [CNT_W-1:0]   base_p1;
  logic               send_ok;
  logic               send_more;
  logic [STAMP_W-1:0] age;
  logic               hit;
  logic               blocked;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign can_emit    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign total_sat = (int'(cfg_i.total) > MAX_FRAMES) ? CNT_W'(MAX_FRAMES)
                                                     : CNT_W'(cfg_i.total);
  assign win_sat   = (cfg_i.window == '0) ? WIN_W'(1) :
                     (int'(cfg_i.window) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW)
                                                       : WIN_W'(cfg_i.window);

  // window limit is base plus window, bounded again by the total
  assign lim       = LIM_W'(base_q) + LIM_W'(win_q);
  assign next_w    = LIM_W'(next_q);
  assign next_p1_w = next_w + LIM_W'(1);
  assign base_p1   = base_q + CNT_W'(1);
  assign send_ok   = (next_w < lim) && (next_w < LIM_W'(total_q));
  assign send_more = (next_p1_w < lim) && (next_p1_w < LIM_W'(total_q));

  assign age     = tick_q - stamp_rd_i;
  assign hit     = rd_vld_q && !ack_rd_i && (age >= STAMP_W'(cfg_i.timeout));
  assign blocked = hit && hold_vld_q && !can_emit;

  always_comb begin
    state_d    = state_q;
    base_d     = base_q;
    next_d     = next_q;
    tick_d     = tick_q;
    active_d   = active_q;
    total_d    = total_q;
    win_d      = win_q;
    scan_d     = scan_q;
    rd_idx_d   = rd_idx_q;
    rd_vld_d   = rd_vld_q;
    hold_d     = hold_q;
    hold_vld_d = hold_vld_q;
    emit       = 1'b0;
    emit_item  = '0;
    ack_wr_o   = '0;
    stamp_wr_o = '0;
    raddr_o    = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_item_i.action)
            ACT_START: begin
              total_d  = total_sat;
              win_d    = win_sat;
              base_d   = '0;
              next_d   = '0;
              active_d = 1'b1;
              state_d  = S_FIN;
            end
            ACT_ACK: begin
              if (active_q && (CNT_W'(in_item_i.ack_number) < next_q)) begin
                ack_wr_o.we    = 1'b1;
                ack_wr_o.waddr = IDX_W'(in_item_i.ack_number);
                ack_wr_o.wdata = 1'b1;
                state_d        = S_WALK_RD;
              end
            end
            ACT_TICK: begin
              tick_d = tick_q + STAMP_W'(1);
              if (active_q) begin
                scan_d     = base_q;
                rd_vld_d   = 1'b0;
                hold_vld_d = 1'b0;
                state_d    = S_TSCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_WALK_RD: begin
        if (base_q < next_q) begin
          raddr_o = base_q[IDX_W-1:0];
          state_d = S_WALK_CHK;
        end else begin
          state_d = S_FIN;
        end
      end

      // one base step per cycle, next read issued as the current one lands
      S_WALK_CHK: begin
        if (ack_rd_i) begin
          base_d = base_p1;
          if (base_p1 < next_q) begin
            raddr_o = base_p1[IDX_W-1:0];
          end else begin
            state_d = S_FIN;
          end
        end else begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        if (base_q >= total_q) begin
          if (can_emit) begin
            emit                   = 1'b1;
            emit_item.frame_number = '0;
            emit_item.kind         = KIND_END;
            emit_item.last         = 1'b1;
            active_d               = 1'b0;
            state_d                = S_IDLE;
          end
        end else begin
          state_d = S_SEND;
        end
      end

      S_SEND: begin
        if (!send_ok) begin
          state_d = S_IDLE;
        end else if (can_emit) begin
          emit                   = 1'b1;
          emit_item.frame_number = FRAME_W'(next_q[IDX_W-1:0]);
          emit_item.kind         = KIND_NEW;
          emit_item.last         = !send_more;
          ack_wr_o.we            = 1'b1;
          ack_wr_o.waddr         = next_q[IDX_W-1:0];
          ack_wr_o.wdata         = 1'b0;
          stamp_wr_o.we          = 1'b1;
          stamp_wr_o.waddr       = next_q[IDX_W-1:0];
          stamp_wr_o.wdata       = tick_q;
          next_d                 = next_q + CNT_W'(1);
          if (!send_more) begin
            state_d = S_IDLE;
          end
        end
      end

      // one hit is held back so the final one can carry last
      S_TSCAN: begin
        if (!rd_vld_q && (scan_q >= next_q)) begin
          if (hold_vld_q) begin
            if (can_emit) begin
              emit                   = 1'b1;
              emit_item.frame_number = FRAME_W'(hold_q);
              emit_item.kind         = KIND_RETX;
              emit_item.last         = 1'b1;
              hold_vld_d             = 1'b0;
              state_d                = S_IDLE;
            end
          end else begin
            state_d = S_IDLE;
          end
        end else if (blocked) begin
          // output full: read the same entry again next cycle
          raddr_o  = rd_idx_q;
          rd_vld_d = 1'b1;
        end else begin
          if (hit) begin
            if (hold_vld_q) begin
              emit                   = 1'b1;
              emit_item.frame_number = FRAME_W'(hold_q);
              emit_item.kind         = KIND_RETX;
              emit_item.last         = 1'b0;
            end
            hold_d           = rd_idx_q;
            hold_vld_d       = 1'b1;
            stamp_wr_o.we    = 1'b1;
            stamp_wr_o.waddr = rd_idx_q;
            stamp_wr_o.wdata = tick_q;
          end
          if (scan_q < next_q) begin
            raddr_o  = scan_q[IDX_W-1:0];
            rd_idx_d = scan_q[IDX_W-1:0];
            rd_vld_d = 1'b1;
            scan_d   = scan_q + CNT_W'(1);
          end else begin
            rd_vld_d = 1'b0;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = emit_item;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= '0;
      next_q      <= '0;
      tick_q      <= '0;
      active_q    <= 1'b0;
      total_q     <= CNT_W'(TOTAL_RST);
      win_q       <= WIN_W'(WINDOW_RST);
      scan_q      <= '0;
      rd_vld_q    <= 1'b0;
      hold_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      next_q      <= next_d;
      tick_q      <= tick_d;
      active_q    <= active_d;
      total_q     <= total_d;
      win_q       <= win_d;
      scan_q      <= scan_d;
      rd_vld_q    <= rd_vld_d;
      hold_vld_q  <= hold_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    hold_q   <= hold_d;
    out_q    <= out_d;
  end

endmodule

>>> rtl/selective_repeat_arq_sender_top.sv
// channel  | direction | handshake                | payload
// in       | input     | in_valid_i / in_stall_o  | in_item_i   (action, ack_number)
// out      | output    | out_valid_o / out_stall_i| out_item_o  (frame_number, kind, last)
// cfg      | input     | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// start clears base and next and sends new frames up to the window;
// an ack in range marks its frame, moves the base over acked frames, then sends new frames;
// an active tick rescans the outstanding frames and resends those timed out;
// an ignored ack and an unused action do nothing, and an idle tick only advances the tick count.
// reset needs no clearing pass: entries are only read below the next-frame count.
// a ready result waits while the output is full; one item at a time.
module selective_repeat_arq_sender_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  srarq_pkg::in_item_t               in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output srarq_pkg::out_item_t              out_item_o,
  input  logic                              cfg_we_i,
  input  logic [srarq_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [srarq_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import srarq_pkg::*;

  cfg_t               cfg_q, cfg_d;
  ack_wr_t            ack_wr;
  stamp_wr_t          stamp_wr;
  logic [IDX_W-1:0]   raddr;
  logic               ack_rd;
  logic [STAMP_W-1:0] stamp_rd;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TOTAL:   cfg_d.total   = TOTAL_W'(cfg_data_i);
        CFG_WINDOW:  cfg_d.window  = cfg_data_i[WINDOW_W-1:0];
        CFG_TIMEOUT: cfg_d.timeout = TIMEOUT_W'(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.total   <= TOTAL_RST;
      cfg_q.window  <= WINDOW_RST;
      cfg_q.timeout <= TIMEOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  srarq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .ack_wr_o    (ack_wr),
    .stamp_wr_o  (stamp_wr),
    .raddr_o     (raddr),
    .ack_rd_i    (ack_rd),
    .stamp_rd_i  (stamp_rd)
  );

  srarq_ram #(
    .WIDTH (1),
    .DEPTH (MAX_FRAMES)
  ) u_ack_ram (
    .clk_i   (clk_i),
    .we_i    (ack_wr.we),
    .waddr_i (ack_wr.waddr),
    .wdata_i (ack_wr.wdata),
    .raddr_i (raddr),
    .rdata_o (ack_rd)
  );

  srarq_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (MAX_FRAMES)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (stamp_wr.we),
    .waddr_i (stamp_wr.waddr),
    .wdata_i (stamp_wr.wdata),
    .raddr_i (raddr),
    .rdata_o (stamp_rd)
  );

endmodule
